// ----- rtl/wpba_pkg.sv -----
// Shared types and constants for the weighted patch blend accumulator.
// Used by the stream interface users, the controller, the datapath and the divider.
package wpba_pkg;

    // Field widths.
    localparam int COORD_W   = 6;
    localparam int CLASS_W   = 2;
    localparam int LOGIT_W   = 32;
    localparam int WEIGHT_W  = 16;
    localparam int DIM_REG_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 48;
    localparam int CSUM_W    = 64;
    localparam int WSUM_W    = 24;
    localparam int RESULT_W  = 32;

    // Operation codes.
    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

    localparam logic [DIM_REG_W-1:0] DIM_RESET  = 7'd64;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_ONE = 16'd32768;

    localparam logic [RESULT_W-1:0] RESULT_MAX = 32'h7FFF_FFFF;
    localparam logic [RESULT_W-1:0] RESULT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                       operation;
        logic [CLASS_W-1:0]         class_index;
        logic [COORD_W-1:0]         voxel_z;
        logic [COORD_W-1:0]         voxel_y;
        logic [COORD_W-1:0]         voxel_x;
        logic signed [LOGIT_W-1:0]  logit;
        logic [WEIGHT_W-1:0]        weight;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] normalized_value;
        logic                       uncovered;
        logic                       out_of_range;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DIM_REG_W-1:0] data;
    } cfg_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic in_ready;
        logic clear;
        logic acc_write;
        logic flag_write;
        logic div_start;
        logic div_write;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic accept;
        logic accept_read;
        logic clear_last;
        logic item_valid;
        logic wsum_zero;
        logic out_free;
        logic div_done;
    } ctrl_status_t;

endpackage

// ----- rtl/wpba_stream_if.sv -----
// Valid/ready stream channel carrying one payload item per handshake.
// The payload type is set at instantiation; no package dependency.
interface wpba_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/wpba_div.sv -----
// Bit-serial signed-by-unsigned divider with Q16.16 saturation of the quotient.
// Depends on wpba_pkg for widths and saturation limits.
module wpba_div
    import wpba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CSUM_W-1:0]   dividend,
    input  logic [WSUM_W-1:0]   divisor,
    output logic                done,
    output logic [RESULT_W-1:0] quotient
);
    localparam int STEP_W = $clog2(CSUM_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic              neg_reg;
    logic [CSUM_W-1:0] quo_reg;
    logic [WSUM_W-1:0] rem_reg;
    logic [WSUM_W-1:0] dvs_reg;

    logic [CSUM_W-1:0] mag_in;
    logic [WSUM_W:0]   rem_sh;
    logic [WSUM_W:0]   diff;
    logic              take;
    logic [CSUM_W-1:0] neg_quo;

    assign mag_in = dividend[CSUM_W-1] ? (~dividend + CSUM_W'(1)) : dividend;
    assign rem_sh = {rem_reg, quo_reg[CSUM_W-1]};
    assign take   = rem_sh >= {1'b0, dvs_reg};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
        end
        else if (busy_reg)
        begin
            count_next = count_reg + STEP_W'(1);
            if (count_reg == STEP_W'(CSUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Dividend magnitude shifts out of quo_reg as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[CSUM_W-1];
            quo_reg <= mag_in;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
            quo_reg <= {quo_reg[CSUM_W-2:0], take};
        end
    end

    assign neg_quo = ~quo_reg + CSUM_W'(1);

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > {{(CSUM_W-RESULT_W){1'b0}}, RESULT_MIN})
                quotient = RESULT_MIN;
            else
                quotient = neg_quo[RESULT_W-1:0];
        end
        else
        begin
            if (quo_reg > {{(CSUM_W-RESULT_W){1'b0}}, RESULT_MAX})
                quotient = RESULT_MAX;
            else
                quotient = quo_reg[RESULT_W-1:0];
        end
    end

    assign done = done_reg;
endmodule

// ----- rtl/wpba_ctrl.sv -----
// Sequencing state machine: clearing pass, accumulate write-back, read evaluation.
// Depends on wpba_pkg for the command and status structs.
module wpba_ctrl
    import wpba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_EVAL,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.accept)
                    state_next = status.accept_read ? S_EVAL : S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_write = 1'b1;
                state_next    = S_IDLE;
            end
            S_EVAL:
            begin
                // Flagged reads finish here; covered voxels go to the divider.
                if (!status.item_valid || status.wsum_zero)
                begin
                    if (status.out_free)
                    begin
                        cmd.flag_write = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end
endmodule

// ----- rtl/wpba_dpath.sv -----
// Datapath: configuration registers, address decode, sum memories, saturating
// accumulation, divider and output register. Depends on wpba_pkg and wpba_div.
module wpba_dpath
    import wpba_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int NUM_CLASSES = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    wpba_stream_if.sink          items,
    wpba_stream_if.source        results,
    wpba_stream_if.sink          cfg,
    input  ctrl_cmd_t            cmd,
    output ctrl_status_t         status
);
    localparam int VOXELS      = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int CLASS_DEPTH = NUM_CLASSES * VOXELS;
    localparam int VOX_W       = $clog2(VOXELS);
    localparam int CA_W        = $clog2(CLASS_DEPTH);

    logic [CSUM_W-1:0] class_mem [CLASS_DEPTH];
    logic [WSUM_W-1:0] wsum_mem  [VOXELS];

    logic [DIM_REG_W-1:0] depth_reg, height_reg, width_reg;
    logic [CA_W-1:0]      clr_addr_reg;

    // Item registers.
    logic                valid_reg;
    logic                cls_zero_reg;
    logic [VOX_W-1:0]    vox_reg;
    logic [CA_W-1:0]     caddr_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [PROD_W-1:0]   product_reg;
    logic [CSUM_W-1:0]   class_rd_reg;
    logic [WSUM_W-1:0]   wsum_rd_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic                accept;
    in_item_t            item;
    logic [WEIGHT_W-1:0] w_clamp;
    logic                in_range;
    logic [31:0]         vox_full;
    logic [31:0]         caddr_full;
    logic [PROD_W:0]     prod_full;

    logic [CSUM_W-1:0] prod_ext;
    logic [CSUM_W-1:0] sum_raw;
    logic              sum_ovf;
    logic [CSUM_W-1:0] csum_next;
    logic [WSUM_W:0]   wsum_raw;
    logic [WSUM_W-1:0] wsum_next;

    logic              cw_en;
    logic [CA_W-1:0]   cw_addr;
    logic [CSUM_W-1:0] cw_data;
    logic              ww_en;
    logic [VOX_W-1:0]  ww_addr;
    logic [WSUM_W-1:0] ww_data;
    logic              clr_in_wsum;

    logic                div_done;
    logic [RESULT_W-1:0] div_quotient;

    assign item        = items.payload;
    assign accept      = items.valid && items.ready;
    assign items.ready = cmd.in_ready;
    assign cfg.ready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            width_reg  <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                CFG_DEPTH:  depth_reg  <= cfg.payload.data;
                CFG_HEIGHT: height_reg <= cfg.payload.data;
                CFG_WIDTH:  width_reg  <= cfg.payload.data;
                default:    ;
            endcase
        end
    end

    // Input decode. The bound on each axis is the smaller of the register and MAX_DIM.
    always_comb
    begin
        w_clamp  = (item.weight > WEIGHT_ONE) ? WEIGHT_ONE : item.weight;
        in_range = (32'(item.voxel_z) < 32'(depth_reg))  && (32'(item.voxel_z) < 32'(MAX_DIM))
                && (32'(item.voxel_y) < 32'(height_reg)) && (32'(item.voxel_y) < 32'(MAX_DIM))
                && (32'(item.voxel_x) < 32'(width_reg))  && (32'(item.voxel_x) < 32'(MAX_DIM))
                && (32'(item.class_index) < 32'(NUM_CLASSES));
        vox_full   = (32'(item.voxel_z) * 32'(MAX_DIM) + 32'(item.voxel_y)) * 32'(MAX_DIM)
                   + 32'(item.voxel_x);
        caddr_full = 32'(item.class_index) * 32'(VOXELS) + vox_full;
        prod_full  = $signed(item.logit) * $signed({1'b0, w_clamp});
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            valid_reg    <= in_range;
            cls_zero_reg <= (item.class_index == '0);
            vox_reg      <= vox_full[VOX_W-1:0];
            caddr_reg    <= caddr_full[CA_W-1:0];
            w_reg        <= w_clamp;
            product_reg  <= prod_full[PROD_W-1:0];
        end
    end

    // Saturating accumulation.
    always_comb
    begin
        prod_ext  = {{(CSUM_W-PROD_W){product_reg[PROD_W-1]}}, product_reg};
        sum_raw   = class_rd_reg + prod_ext;
        sum_ovf   = (class_rd_reg[CSUM_W-1] == prod_ext[CSUM_W-1])
                 && (sum_raw[CSUM_W-1] != class_rd_reg[CSUM_W-1]);
        if (sum_ovf)
            csum_next = class_rd_reg[CSUM_W-1] ? {1'b1, {(CSUM_W-1){1'b0}}}
                                               : {1'b0, {(CSUM_W-1){1'b1}}};
        else
            csum_next = sum_raw;
        wsum_raw  = {1'b0, wsum_rd_reg} + (WSUM_W+1)'(w_reg);
        wsum_next = wsum_raw[WSUM_W] ? '1 : wsum_raw[WSUM_W-1:0];
    end

    // Memory write ports: the clearing pass or an accumulate write-back.
    always_comb
    begin
        clr_in_wsum = 32'(clr_addr_reg) < 32'(VOXELS);
        cw_en   = cmd.clear || (cmd.acc_write && valid_reg);
        cw_addr = cmd.clear ? clr_addr_reg : caddr_reg;
        cw_data = cmd.clear ? '0 : csum_next;
        ww_en   = (cmd.clear && clr_in_wsum) || (cmd.acc_write && valid_reg && cls_zero_reg);
        ww_addr = cmd.clear ? clr_addr_reg[VOX_W-1:0] : vox_reg;
        ww_data = cmd.clear ? '0 : wsum_next;
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
            class_mem[cw_addr] <= cw_data;
        if (accept)
            class_rd_reg <= class_mem[caddr_full[CA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ww_en)
            wsum_mem[ww_addr] <= ww_data;
        if (accept)
            wsum_rd_reg <= wsum_mem[vox_full[VOX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear)
            clr_addr_reg <= clr_addr_reg + CA_W'(1);
    end

    wpba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (class_rd_reg),
        .divisor  (wsum_rd_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.flag_write || cmd.div_write)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flag_write)
        begin
            out_item_reg.normalized_value <= '0;
            out_item_reg.uncovered        <= valid_reg;
            out_item_reg.out_of_range     <= !valid_reg;
        end
        else if (cmd.div_write)
        begin
            out_item_reg.normalized_value <= div_quotient;
            out_item_reg.uncovered        <= 1'b0;
            out_item_reg.out_of_range     <= 1'b0;
        end
    end

    assign results.valid   = out_valid_reg;
    assign results.payload = out_item_reg;

    always_comb
    begin
        status.accept      = accept;
        status.accept_read = accept && (item.operation == OP_READ);
        status.clear_last  = (clr_addr_reg == CA_W'(CLASS_DEPTH - 1));
        status.item_valid  = valid_reg;
        status.wsum_zero   = (wsum_rd_reg == '0);
        status.out_free    = !out_valid_reg || results.ready;
        status.div_done    = div_done;
    end
endmodule

// ----- rtl/weighted_patch_blend_accumulator_unit.sv -----
// Top level of the weighted patch blend accumulator: controller plus datapath.
// Depends on wpba_pkg, wpba_stream_if, wpba_ctrl and wpba_dpath.
//
//   channel   role     payload     handshake
//   items     sink     in_item_t   valid/ready, accepted when both high
//   results   source   out_item_t  valid/ready, taken when both high
//   cfg       sink     cfg_item_t  valid/ready, ready is always high
//
// An accumulate item reads the memories at acceptance and writes them back in the next
// cycle. A flagged read goes from the evaluation state to the output register; a covered
// read waits for the bit-serial divider, which retires one quotient bit per cycle.
// After reset a clearing pass zeroes all NUM_CLASSES * MAX_DIM^3 class-sum entries
// (1,048,576 at the defaults) and every weight sum; no item is accepted until it ends.
// A result waits in the output register; a new item is accepted meanwhile, but a read
// holds its result until the register is free.
module weighted_patch_blend_accumulator_unit
    import wpba_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int NUM_CLASSES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    wpba_stream_if.sink   items,
    wpba_stream_if.source results,
    wpba_stream_if.sink   cfg
);
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    wpba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    wpba_dpath #(
        .MAX_DIM     (MAX_DIM),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status)
    );
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for weighted_patch_blend_accumulator_unit.
// Uses wpba_pkg types and wpba_stream_if channels. A directed table is followed by
// random phases; results are checked against a voxel blend predictor or typed-in flags.
module tb;
    import wpba_pkg::*;

    localparam int          MAX_DIM        = 64;
    localparam int          NUM_CLASSES    = 4;
    localparam int          VOXELS         = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int unsigned WSUM_LIMIT     = 32'h00FF_FFFF;
    localparam int          CLEAR_CYCLES   = NUM_CLASSES * VOXELS;
    localparam int          RUN_LIMIT      = 4 * (CLEAR_CYCLES + 200000);
    localparam int          DRAIN_CYCLES   = 80;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_ITEMS    = 50;
    localparam int          HOT_VOXELS     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        bit        is_cfg;
        cfg_item_t cfg;
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wpba_stream_if #(.payload_t(in_item_t))  item_ch ();
    wpba_stream_if #(.payload_t(out_item_t)) result_ch ();
    wpba_stream_if #(.payload_t(cfg_item_t)) cfg_ch ();

    weighted_patch_blend_accumulator_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // Predictor state: sparse copies of both stores and the dimension registers.
    longint                 class_sum_mem  [int];
    int unsigned            weight_sum_mem [int];
    logic [DIM_REG_W-1:0]   dim_reg [3];

    out_item_t              pending_reads [$];
    stim_row_t              directed_rows [$];
    logic [3*COORD_W-1:0]   hot_vox [HOT_VOXELS];

    int error_count = 0;
    int cycle_count = 0;
    bit src_no_idle = 1'b0;
    bit snk_no_idle = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("[weighted_patch_blend_accumulator_unit] ERROR");
            $finish;
        end
    end

    function automatic int dim_bound(logic [DIM_REG_W-1:0] r);
        return (r > MAX_DIM) ? MAX_DIM : int'(r);
    endfunction

    function automatic void apply_dim_register(cfg_item_t c);
        if (c.index != CFG_UNUSED)
            dim_reg[c.index] = c.data;
    endfunction

    function automatic void add_row(stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Updates the stores for an accumulate item; returns 1 with the result for a read.
    function automatic bit blend_voxel(input in_item_t it, output out_item_t res);
        int unsigned w;
        int unsigned ws;
        int unsigned vox;
        int unsigned key;
        longint      lg;
        longint      cs;
        longint      sum;
        longint      q;
        bit          in_vol;
        w = 32'((it.weight > WEIGHT_ONE) ? WEIGHT_ONE : it.weight);
        in_vol = it.voxel_z < dim_bound(dim_reg[CFG_DEPTH])
              && it.voxel_y < dim_bound(dim_reg[CFG_HEIGHT])
              && it.voxel_x < dim_bound(dim_reg[CFG_WIDTH])
              && it.class_index < NUM_CLASSES;
        vox = 32'({it.voxel_z, it.voxel_y, it.voxel_x});
        key = it.class_index * VOXELS + vox;
        cs  = class_sum_mem.exists(key) ? class_sum_mem[key] : 0;
        ws  = weight_sum_mem.exists(vox) ? weight_sum_mem[vox] : 0;
        res = '0;
        if (it.operation == OP_ACCUMULATE)
        begin
            if (!in_vol)
                return 1'b0;
            lg  = $signed(it.logit);
            sum = cs + lg * longint'(w);
            // Signed overflow shows as a sign flip against two like-signed operands.
            if (cs[63] == lg[63] && sum[63] != cs[63] && w != 0)
                sum = cs[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
            class_sum_mem[key] = sum;
            if (it.class_index == 0)
            begin
                ws = ws + w;
                weight_sum_mem[vox] = (ws > WSUM_LIMIT) ? WSUM_LIMIT : ws;
            end
            return 1'b0;
        end
        if (!in_vol)
            res.out_of_range = 1'b1;
        else if (ws == 0)
            res.uncovered = 1'b1;
        else
        begin
            q = cs / longint'(ws);
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            res.normalized_value = q[31:0];
        end
        return 1'b1;
    endfunction

    function automatic in_item_t make_item(logic op, logic [CLASS_W-1:0] cls,
                                           logic [COORD_W-1:0] z, logic [COORD_W-1:0] y,
                                           logic [COORD_W-1:0] x, logic [LOGIT_W-1:0] lg,
                                           logic [WEIGHT_W-1:0] w);
        in_item_t it;
        it.operation   = op;
        it.class_index = cls;
        it.voxel_z     = z;
        it.voxel_y     = y;
        it.voxel_x     = x;
        it.logit       = lg;
        it.weight      = w;
        return it;
    endfunction

    function automatic stim_row_t acc_row(logic [CLASS_W-1:0] cls, logic [COORD_W-1:0] z,
                                          logic [COORD_W-1:0] y, logic [COORD_W-1:0] x,
                                          logic [LOGIT_W-1:0] lg, logic [WEIGHT_W-1:0] w);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.cfg    = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        r.item   = make_item(OP_ACCUMULATE, cls, z, y, x, lg, w);
        return r;
    endfunction

    function automatic stim_row_t read_row(logic [CLASS_W-1:0] cls, logic [COORD_W-1:0] z,
                                           logic [COORD_W-1:0] y, logic [COORD_W-1:0] x);
        stim_row_t r;
        r = acc_row(cls, z, y, x, '0, '0);
        r.item.operation = OP_READ;
        return r;
    endfunction

    // A read whose result is a flagged zero, typed in directly.
    function automatic stim_row_t flag_row(logic [CLASS_W-1:0] cls, logic [COORD_W-1:0] z,
                                           logic [COORD_W-1:0] y, logic [COORD_W-1:0] x,
                                           logic unc, logic oor);
        stim_row_t r;
        r = read_row(cls, z, y, x);
        r.typed = 1'b1;
        r.want  = {32'sd0, unc, oor};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [DIM_REG_W-1:0] data);
        stim_row_t r;
        r = acc_row('0, '0, '0, '0, '0, '0);
        r.is_cfg = 1'b1;
        r.cfg    = {idx, data};
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int bound);
        return (bound == 0) ? COORD_W'($urandom_range(0, MAX_DIM - 1))
                            : COORD_W'($urandom_range(0, bound - 1));
    endfunction

    // Most items hit a small pool of voxels so that reads find accumulated data.
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        it.operation   = 1'($urandom_range(0, 1));
        it.class_index = CLASS_W'($urandom_range(0, 3));
        {it.voxel_z, it.voxel_y, it.voxel_x} = (3*COORD_W)'($urandom_range(0, VOXELS - 1));
        if ($urandom_range(0, 1) == 1)
            it.logit = $urandom();
        else
            it.logit = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        if ($urandom_range(0, 4) == 0)
            it.weight = WEIGHT_W'($urandom_range(0, 16'hFFFF));
        else
            it.weight = WEIGHT_W'($urandom_range(0, WEIGHT_ONE));
        if ($urandom_range(0, 99) < 85)
        begin
            {it.voxel_z, it.voxel_y, it.voxel_x} = hot_vox[$urandom_range(0, HOT_VOXELS - 1)];
            pick = $urandom_range(0, 99);
            it.operation = (pick < 60) ? OP_ACCUMULATE : OP_READ;
            if (pick < 30)
                it.class_index = '0;
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                             input out_item_t want = '0);
        int        gap;
        out_item_t res;
        gap = src_no_idle ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (blend_voxel(it, res))
            pending_reads.insert(pending_reads.size(), typed ? want : res);
    endtask

    // Registers change only once the block has finished all earlier items.
    task automatic write_dim_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] data);
        cfg_item_t c;
        c = {idx, data};
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= c;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_dim_register(c);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase();
        int dice;
        for (int i = 0; i < 3; i++)
        begin
            dice = $urandom_range(0, 99);
            if (dice < 5)
                write_dim_register(CFG_IDX_W'(i), '0);
            else if (dice < 12)
                write_dim_register(CFG_IDX_W'(i), DIM_REG_W'($urandom_range(65, 127)));
            else if (dice < 40)
                write_dim_register(CFG_IDX_W'(i), DIM_REG_W'($urandom_range(1, 8)));
            else
                write_dim_register(CFG_IDX_W'(i), DIM_REG_W'($urandom_range(1, 64)));
        end
        if ($urandom_range(0, 3) == 0)
            write_dim_register(CFG_UNUSED, DIM_REG_W'($urandom_range(0, 127)));
        for (int h = 0; h < HOT_VOXELS; h++)
            hot_vox[h] = {rand_coord(dim_bound(dim_reg[CFG_DEPTH])),
                          rand_coord(dim_bound(dim_reg[CFG_HEIGHT])),
                          rand_coord(dim_bound(dim_reg[CFG_WIDTH]))};
        src_no_idle = ($urandom_range(0, 3) == 0);
        snk_no_idle = ($urandom_range(0, 3) == 0);
        repeat (PHASE_ITEMS) send_item(random_item());
    endtask

    initial
    begin : result_sink
        int        stall;
        out_item_t got;
        out_item_t want;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = snk_no_idle ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            got = result_ch.payload;
            if (pending_reads.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no read pending: value %h uncovered %b range %b",
                         $time, got.normalized_value, got.uncovered, got.out_of_range);
            end
            else
            begin
                want = pending_reads.pop_front();
                if (got.normalized_value !== want.normalized_value)
                begin
                    error_count++;
                    $display("%0t: normalized_value expected %h actual %h",
                             $time, want.normalized_value, got.normalized_value);
                end
                if (got.uncovered !== want.uncovered)
                begin
                    error_count++;
                    $display("%0t: uncovered expected %b actual %b",
                             $time, want.uncovered, got.uncovered);
                end
                if (got.out_of_range !== want.out_of_range)
                begin
                    error_count++;
                    $display("%0t: out_of_range expected %b actual %b",
                             $time, want.out_of_range, got.out_of_range);
                end
            end
        end
    end

    initial
    begin : stimulus
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.payload  = '0;
        for (int i = 0; i < 3; i++)
            dim_reg[i] = DIM_RESET;

        // Nothing has been written yet, so the far corners are uncovered.
        add_row(flag_row(0, 0, 0, 0, 1'b1, 1'b0));
        add_row(flag_row(3, 63, 63, 63, 1'b1, 1'b0));
        // Weight above one is clamped.
        add_row(acc_row(0, 0, 0, 0, 32'h7FFF_FFFF, 16'hFFFF));
        add_row(read_row(0, 0, 0, 0));
        add_row(acc_row(1, 0, 0, 0, 32'h8000_0000, WEIGHT_ONE));
        add_row(read_row(1, 0, 0, 0));
        // A weight sum of one makes large class sums saturate the quotient both ways.
        add_row(acc_row(0, 63, 63, 63, -1, 1));
        add_row(read_row(0, 63, 63, 63));
        add_row(acc_row(2, 63, 63, 63, 32'h7FFF_FFFF, WEIGHT_ONE));
        add_row(read_row(2, 63, 63, 63));
        add_row(acc_row(3, 63, 63, 63, 32'h8000_0000, WEIGHT_ONE));
        add_row(read_row(3, 63, 63, 63));
        add_row(acc_row(0, 1, 2, 3, 5, 0));
        add_row(flag_row(0, 1, 2, 3, 1'b1, 1'b0));
        // Only class 0 adds to the weight sum.
        add_row(acc_row(1, 10, 20, 30, 12345, 1000));
        add_row(flag_row(1, 10, 20, 30, 1'b1, 1'b0));
        // -1 / 2 must truncate toward zero.
        add_row(acc_row(0, 2, 2, 2, -3, 2));
        add_row(acc_row(1, 2, 2, 2, -1, 1));
        add_row(read_row(1, 2, 2, 2));
        add_row(cfg_row(CFG_DEPTH, 5));
        add_row(cfg_row(CFG_HEIGHT, 6));
        add_row(cfg_row(CFG_WIDTH, 7));
        add_row(flag_row(0, 5, 0, 0, 1'b0, 1'b1));
        add_row(acc_row(0, 4, 5, 6, 32'h0064_0000, WEIGHT_ONE));
        add_row(read_row(0, 4, 5, 6));
        // An accumulate outside the volume must leave no trace once the bound grows.
        add_row(acc_row(0, 0, 6, 0, 1, WEIGHT_ONE));
        add_row(flag_row(0, 0, 6, 0, 1'b0, 1'b1));
        add_row(cfg_row(CFG_HEIGHT, 127));
        add_row(flag_row(0, 0, 6, 0, 1'b1, 1'b0));
        add_row(cfg_row(CFG_UNUSED, 0));
        add_row(read_row(0, 4, 5, 6));
        add_row(cfg_row(CFG_WIDTH, 0));
        add_row(flag_row(0, 0, 0, 0, 1'b0, 1'b1));
        add_row(cfg_row(CFG_WIDTH, 127));
        add_row(cfg_row(CFG_DEPTH, 64));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_dim_register(directed_rows[i].cfg.index, directed_rows[i].cfg.data);
            else
                send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        end

        repeat (RANDOM_PHASES) random_phase();

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[weighted_patch_blend_accumulator_unit] OK");
        else
            $display("[weighted_patch_blend_accumulator_unit] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wpba_pkg.sv
rtl/wpba_stream_if.sv
rtl/wpba_div.sv
rtl/wpba_ctrl.sv
rtl/wpba_dpath.sv
rtl/weighted_patch_blend_accumulator_unit.sv
tb/tb.sv
